[hw/rtl/magic_crc16_packet_checker_core_macros.svh]
// Assertion macros shared by the packet checker RTL.
`ifndef MAGIC_CRC16_PACKET_CHECKER_CORE_MACROS_SVH
`define MAGIC_CRC16_PACKET_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MCPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MCPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/mcpc_pkg.sv]
// Package: types, status codes and the CRC-16 byte update for the packet checker.
`timescale 1ns / 1ps
package mcpc_pkg;

   localparam int MAX_PACKET_BYTES_DEF = 256;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_SHORT     = 3'd1;
   localparam logic [2:0] STATUS_BAD_MAGIC = 3'd2;
   localparam logic [2:0] STATUS_BAD_CRC   = 3'd3;
   localparam logic [2:0] STATUS_LONG      = 3'd4;

   // Per-packet state other than the byte count.
   typedef struct packed {
      logic [15:0] crc;
      logic [7:0]  tail0;       // newest byte
      logic [7:0]  tail1;       // byte before it
      logic [7:0]  magic_low;
      logic        magic_match;
   } pkt_state_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic       end_of_packet;
      logic [2:0] status;
   } rsp_item_type;

   localparam pkt_state_type PKT_STATE_RESET = '{
      crc: CRC_INIT, tail0: 8'h00, tail1: 8'h00, magic_low: 8'h00, magic_match: 1'b0};

   // CRC-16, poly 0x1021, MSB first, one byte per call.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc[15:8] ^ b;
      c = c ^ (c >> 4);
      return {crc[7:0], 8'h00} ^ (16'(c) << 12) ^ (16'(c) << 5) ^ 16'(c);
   endfunction

endpackage

[hw/rtl/mcpc_chan_if.sv]
// Valid/ready channel interfaces for request and response items.
`timescale 1ns / 1ps
interface mcpc_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_byte;
   logic        is_last;
   logic [15:0] expected_magic;

   modport source (output valid, rx_byte, is_last, expected_magic, input ready);
   modport sink   (input valid, rx_byte, is_last, expected_magic, output ready);
endinterface

interface mcpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       byte_valid;
   logic       end_of_packet;
   logic [2:0] status;

   modport source (output valid, payload_byte, byte_valid, end_of_packet, status, input ready);
   modport sink   (input valid, payload_byte, byte_valid, end_of_packet, status, output ready);
endinterface

[hw/rtl/mcpc_step.sv]
// Per-byte packet check: CRC update, magic compare, status and next state.
`timescale 1ns / 1ps
module mcpc_step #(
   parameter int MAX_PACKET_BYTES = mcpc_pkg::MAX_PACKET_BYTES_DEF,
   parameter int COUNT_W          = $clog2(MAX_PACKET_BYTES + 1)
) (
   input  logic [COUNT_W-1:0]      count,
   input  mcpc_pkg::pkt_state_type state,
   input  logic [7:0]              rx_byte,
   input  logic                    is_last,
   input  logic [15:0]             expected_magic,
   output logic [COUNT_W-1:0]      count_next,
   output mcpc_pkg::pkt_state_type state_next,
   output logic                    res_valid,
   output mcpc_pkg::rsp_item_type  res_item
);
   import mcpc_pkg::*;

   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_PACKET_BYTES);

   logic        release_byte;
   logic        pass_byte;
   logic [15:0] crc_mid;
   logic [15:0] rx_crc;
   logic [2:0]  status;

   always_comb begin
      release_byte = count >= COUNT_W'(2);
      pass_byte    = count >= COUNT_W'(4);
      crc_mid      = release_byte ? crc16_byte(state.crc, state.tail1) : state.crc;
      rx_crc       = {rx_byte, state.tail0};

      status = STATUS_OK;
      if (is_last) begin
         if (count < COUNT_W'(3)) begin
            status = STATUS_SHORT;
         end else if (!state.magic_match) begin
            status = STATUS_BAD_MAGIC;
         end else if (count == COUNT_MAX) begin
            status = STATUS_LONG;
         end else if (rx_crc != crc_mid) begin
            status = STATUS_BAD_CRC;
         end
      end

      state_next       = state;
      state_next.crc   = crc_mid;
      state_next.tail1 = state.tail0;
      state_next.tail0 = rx_byte;
      if (count == COUNT_W'(0)) begin
         state_next.magic_low = rx_byte;
      end
      if (count == COUNT_W'(1)) begin
         state_next.magic_match = ({rx_byte, state.magic_low} == expected_magic);
      end
      count_next = (count == COUNT_MAX) ? count : count + COUNT_W'(1);
      if (is_last) begin
         state_next = PKT_STATE_RESET;
         count_next = '0;
      end

      res_valid              = pass_byte || is_last;
      res_item.payload_byte  = pass_byte ? state.tail1 : 8'h00;
      res_item.byte_valid    = pass_byte;
      res_item.end_of_packet = is_last;
      res_item.status        = status;
   end

endmodule

[hw/rtl/magic_crc16_packet_checker_core.sv]
// Top level: byte-stream packet checker with magic, length and CRC-16 checks.
`timescale 1ns / 1ps
// Usage
//   req_chan (sink): one received byte per item, with is_last on the final byte
//   and the expected magic, which must hold steady for the first two bytes.
//   rsp_chan (source): one item per released payload byte (byte_valid = 1) and
//   one on the last byte (end_of_packet = 1, status valid); both can coincide.
//   Bytes that cause no result (magic, first CRC-window bytes) produce no item.
// Path: an accepted byte waits in the input register, then its result in the result
//   register, which is fed by one CRC byte update and compare.
// Throughput: one byte per cycle while rsp ready stays high; the CRC byte update sets the path.
// Reset: synchronous; clears the packet state to the start of a packet
//   (count 0, CRC 0xFFFF) and empties both registers.
// Stall: when the receiver holds rsp ready low, the result register keeps its
//   item, the input register still takes one byte, then req ready drops.
//   Items that cause no result keep flowing while the result waits.
module magic_crc16_packet_checker_core #(
   parameter int MAX_PACKET_BYTES = mcpc_pkg::MAX_PACKET_BYTES_DEF
) (
   input logic       clock,
   input logic       reset,
   mcpc_req_if.sink  req_chan,
   mcpc_rsp_if.source rsp_chan
);
   import mcpc_pkg::*;
   `include "magic_crc16_packet_checker_core_macros.svh"

   localparam int COUNT_W = $clog2(MAX_PACKET_BYTES + 1);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic [15:0] in_magic_ff;

   // packet state
   logic [COUNT_W-1:0] count_ff, count_in;
   pkt_state_type      state_ff, state_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;

   logic         res_valid;
   rsp_item_type res_item;
   logic         out_free;
   logic         advance;

   mcpc_step #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
      .COUNT_W(COUNT_W)
   ) u_step (
      .count(count_ff),
      .state(state_ff),
      .rx_byte(in_byte_ff),
      .is_last(in_last_ff),
      .expected_magic(in_magic_ff),
      .count_next(count_in),
      .state_next(state_in),
      .res_valid(res_valid),
      .res_item(res_item)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   // an item with no result never waits on the output side
   assign advance        = in_valid_ff && (!res_valid || out_free);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         state_ff     <= PKT_STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            count_ff <= count_in;
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff  <= req_chan.rx_byte;
         in_last_ff  <= req_chan.is_last;
         in_magic_ff <= req_chan.expected_magic;
      end
      if (advance && res_valid) begin
         rsp_item_ff <= res_item;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.payload_byte  = rsp_item_ff.payload_byte;
   assign rsp_chan.byte_valid    = rsp_item_ff.byte_valid;
   assign rsp_chan.end_of_packet = rsp_item_ff.end_of_packet;
   assign rsp_chan.status        = rsp_item_ff.status;

   `MCPC_ASSERT_NEXT(a_last_clears_packet, clock, reset, advance && in_last_ff, count_ff == '0 && state_ff.crc == CRC_INIT, "packet state not cleared after last byte")
   `MCPC_ASSERT_NOW(a_count_saturates, clock, reset, 1'b1, count_ff <= COUNT_W'(MAX_PACKET_BYTES), "byte count beyond saturation")
   `MCPC_ASSERT_NOW(a_mid_packet_status_ok, clock, reset, rsp_valid_ff && !rsp_item_ff.end_of_packet, rsp_item_ff.byte_valid && rsp_item_ff.status == STATUS_OK, "non-final item without payload or with status")
   `MCPC_ASSERT_NOW(a_no_overwrite, clock, reset, advance && res_valid, out_free, "result register overwritten while full")

endmodule

[sim/testbench.sv]
// Testbench for the magic/CRC-16 packet checker: random packets, scoreboard, backpressure.
`timescale 1ns / 1ps
module testbench;
   import mcpc_pkg::*;

   localparam int MAX_BYTES    = MAX_PACKET_BYTES_DEF;
   localparam int STALL_LIMIT  = 3000;
   localparam int PHASE_ITEMS  = 60;

   typedef enum int {
      FLAW_NONE, FLAW_MAGIC, FLAW_CRC, FLAW_CUT, FLAW_DRIFT, FLAW_NOISE
   } flaw_type;

   // Tracks the packet state and keeps the results it implies, oldest first.
   class packet_scoreboard;
      rsp_item_type expected_q[$];
      int unsigned  mismatches;
      int           count;
      logic [15:0]  crc;
      logic [7:0]   tail_new;
      logic [7:0]   tail_old;
      logic [7:0]   first_byte;
      logic         magic_ok;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         count      = 0;
         crc        = 16'hFFFF;
         tail_new   = 8'h00;
         tail_old   = 8'h00;
         first_byte = 8'h00;
         magic_ok   = 1'b0;
      endfunction

      // Bitwise MSB-first CRC-16, poly 0x1021.
      static function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] data);
         logic [15:0] r;
         r = acc ^ {data, 8'h00};
         for (int i = 0; i < 8; i++)
            r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
         return r;
      endfunction

      function void note_byte(logic [7:0] b, logic last, logic [15:0] magic);
         rsp_item_type exp;
         logic [15:0]  frame_crc;
         exp = '0;
         if (count >= 2) begin
            crc = crc_step(crc, tail_old);
            if (count >= 4) begin
               exp.byte_valid   = 1'b1;
               exp.payload_byte = tail_old;
            end
         end
         if (count == 0)
            first_byte = b;
         else if (count == 1)
            magic_ok = ({b, first_byte} == magic);
         if (last) begin
            exp.end_of_packet = 1'b1;
            frame_crc = {b, tail_new};
            if (count < 3)
               exp.status = STATUS_SHORT;
            else if (!magic_ok)
               exp.status = STATUS_BAD_MAGIC;
            else if (count >= MAX_BYTES)
               exp.status = STATUS_LONG;
            else if (frame_crc != crc)
               exp.status = STATUS_BAD_CRC;
            else
               exp.status = STATUS_OK;
         end
         tail_old = tail_new;
         tail_new = b;
         if (count < MAX_BYTES)
            count++;
         if (last)
            restart();
         if (exp.byte_valid || exp.end_of_packet)
            expected_q.push_back(exp);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type exp;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected item, expected none, got %h", $time, got);
            mismatches++;
            return;
         end
         exp = expected_q.pop_front();
         if (got.payload_byte !== exp.payload_byte) begin
            $display("%0t: payload_byte expected %02h, got %02h", $time,
                     exp.payload_byte, got.payload_byte);
            mismatches++;
         end
         if (got.byte_valid !== exp.byte_valid) begin
            $display("%0t: byte_valid expected %0b, got %0b", $time,
                     exp.byte_valid, got.byte_valid);
            mismatches++;
         end
         if (got.end_of_packet !== exp.end_of_packet) begin
            $display("%0t: end_of_packet expected %0b, got %0b", $time,
                     exp.end_of_packet, got.end_of_packet);
            mismatches++;
         end
         if (got.status !== exp.status) begin
            $display("%0t: status expected %0d, got %0d", $time, exp.status, got.status);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   mcpc_req_if req_chan ();
   mcpc_rsp_if rsp_chan ();

   magic_crc16_packet_checker_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   packet_scoreboard board = new();
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int items_sent    = 0;
   int quiet_cycles  = 0;

   always #1 clock = ~clock;

   initial begin
      req_chan.valid          = 1'b0;
      req_chan.rx_byte        = 8'h00;
      req_chan.is_last        = 1'b0;
      req_chan.expected_magic = 16'h0000;
      rsp_chan.ready          = 1'b0;
   end

   always @(negedge clock)
      rsp_chan.ready = ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.payload_byte  = rsp_chan.payload_byte;
         got.byte_valid    = rsp_chan.byte_valid;
         got.end_of_packet = rsp_chan.end_of_packet;
         got.status        = rsp_chan.status;
         board.check_result(got);
      end
   end

   // Watchdog: cycles in a row with no item moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] b, input logic last, input logic [15:0] magic);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid          = 1'b1;
      req_chan.rx_byte        = b;
      req_chan.is_last        = last;
      req_chan.expected_magic = magic;
      do
         @(posedge clock);
      while (!req_chan.ready);
      board.note_byte(b, last, magic);
      items_sent++;
      @(negedge clock);
   endtask

   // keep: bytes sent for a cut packet (0 picks a random length).
   task automatic send_packet(input logic [15:0] magic, input int plen, input flaw_type flaw,
                              input int keep);
      logic [7:0]  frame[$];
      logic [15:0] crc;
      logic [15:0] magic_in;
      int          total;
      int          pos;
      frame.push_back(magic[7:0]);
      frame.push_back(magic[15:8]);
      for (int i = 0; i < plen; i++)
         frame.push_back(8'($urandom_range(255)));
      crc = 16'hFFFF;
      foreach (frame[i])
         crc = packet_scoreboard::crc_step(crc, frame[i]);
      frame.push_back(crc[7:0]);
      frame.push_back(crc[15:8]);
      total    = frame.size();
      magic_in = magic;
      case (flaw)
         FLAW_MAGIC: begin
            magic_in = magic ^ (16'h1 << $urandom_range(15));
         end
         FLAW_CRC: begin
            pos = total - 1 - $urandom_range(1);
            frame[pos] = frame[pos] ^ (8'h1 << $urandom_range(7));
         end
         FLAW_CUT: begin
            total = (keep > 0) ? keep : $urandom_range(1, total - 1);
         end
         FLAW_NOISE: begin
            total = $urandom_range(1, (total < 8) ? total : 8);
            foreach (frame[i])
               frame[i] = 8'($urandom_range(255));
         end
         default: ;
      endcase
      for (int i = 0; i < total; i++) begin
         // Magic only matters on the second byte; vary it elsewhere on purpose.
         if ((flaw == FLAW_DRIFT && i >= 2) || flaw == FLAW_NOISE)
            magic_in = 16'($urandom_range(65535));
         send_byte(frame[i], i == total - 1, magic_in);
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct);
      int       roll;
      int       plen;
      flaw_type flaw;
      int       stop_at;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
         plen = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         roll = $urandom_range(99);
         if (roll < 60)      flaw = FLAW_NONE;
         else if (roll < 68) flaw = FLAW_MAGIC;
         else if (roll < 76) flaw = FLAW_CRC;
         else if (roll < 84) flaw = FLAW_CUT;
         else if (roll < 92) flaw = FLAW_DRIFT;
         else                flaw = FLAW_NOISE;
         send_packet(16'($urandom_range(65535)), plen, flaw, 0);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty payload, extreme bytes, short packets, bad magic, bad CRC.
      send_packet(16'h0000, 0, FLAW_NONE, 0);
      send_packet(16'hFFFF, 1, FLAW_NONE, 0);
      send_packet(16'h00FF, 1, FLAW_CUT, 1);
      send_packet(16'hFF00, 1, FLAW_CUT, 2);
      send_packet(16'h8001, 1, FLAW_CUT, 3);
      send_packet(16'h1234, 0, FLAW_MAGIC, 0);
      send_packet(16'hA55A, 1, FLAW_CRC, 0);

      run_phase(0, 0);
      run_phase(81, 0);
      run_phase(0, 81);
      run_phase(34, 34);

      // One byte past the length limit: count saturates, status reports too long.
      send_packet(16'($urandom_range(65535)), MAX_BYTES - 3, FLAW_NONE, 0);

      req_chan.valid = 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/mcpc_pkg.sv
hw/rtl/mcpc_chan_if.sv
hw/rtl/mcpc_step.sv
hw/rtl/magic_crc16_packet_checker_core.sv
sim/testbench.sv
